// ===== hw/rtl/dragonfly_plus_minimal_route_macros.svh =====
// Assertion macros shared by the route selection RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef DRAGONFLY_PLUS_MINIMAL_ROUTE_MACROS_SVH
`define DRAGONFLY_PLUS_MINIMAL_ROUTE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define DFPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define DFPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DFPR_ASSERT_IMP(lbl, ante, cons, msg)
`define DFPR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/dfpr_pkg.sv =====
`timescale 1ns / 1ps

package dfpr_pkg;

  localparam int DFPR_MAX_GROUPS   = 64;
  localparam int DFPR_NODE_ID_BITS = 12;
  localparam int DFPR_PORT_BITS    = 8;

  // Raw width of the size registers and width of every rotor.
  localparam int RAW_W    = 7;
  localparam int ROTOR_W  = 6;
  localparam int PORT_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTERS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUPS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COVERING = 2'd3;

  localparam logic [RAW_W-1:0] ROUTERS_RESET  = 7'd4;
  localparam logic [RAW_W-1:0] GROUPS_RESET   = 7'd4;
  localparam logic [RAW_W-1:0] COVERING_RESET = 7'd1;
  localparam logic [RAW_W-1:0] ROTOR_LIMIT    = 7'd64;

  typedef enum logic [1:0] {
    KIND_EJECT  = 2'd0,
    KIND_UPLINK = 2'd1,
    KIND_LOCAL  = 2'd2,
    KIND_GLOBAL = 2'd3
  } route_kind_e;

  // Effective (clamped) sizes and the write strobe.
  typedef struct packed {
    logic             wr;
    logic [RAW_W-1:0] a;
    logic [RAW_W-1:0] cov;
  } cfg_t;

endpackage

// ===== hw/rtl/dragonfly_plus_minimal_route.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake                    | Payload
// ---------+------------------------------+------------------------------------
// input    | in_valid_i / in_stall_o      | eject_switch_i, eject_port_i
// result   | out_valid_o / out_stall_i    | out_port_o, route_kind_o
// config   | cfg_we_i (write only)        | cfg_index_i, cfg_data_i
//
// Steps: an ejection or leaf uplink decision holds the input from its transfer until the
//   result is loaded and the next packet can be taken; a spine decision (local group or
//   global link) makes two passes through the shared one-bit-per-cycle divider, and a
//   global link adds the group rotor read and the port sum.
// After reset or any register write the first packet adds two divider passes to derive
//   this switch's row, group and uplink rotor start.
// Reset and every register write start a clearing pass over all MAX_GROUPS entries of the
//   group rotor memory; in_stall_o stays high for its length.
// One packet is in work at a time; a finished result waits in the output register, so a
//   new packet is taken while out_stall_i holds the previous result.

`include "dragonfly_plus_minimal_route_macros.svh"

module dragonfly_plus_minimal_route import dfpr_pkg::*; #(
  parameter int MAX_GROUPS   = DFPR_MAX_GROUPS,
  parameter int NODE_ID_BITS = DFPR_NODE_ID_BITS,
  parameter int PORT_BITS    = DFPR_PORT_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input transfer
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [NODE_ID_BITS-1:0] eject_switch_i,
  input  logic [PORT_W-1:0]       eject_port_i,
  // result transfer
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [PORT_W-1:0]       out_port_o,
  output logic [1:0]              route_kind_o,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [((NODE_ID_BITS > RAW_W) ? NODE_ID_BITS : RAW_W)-1:0] cfg_data_i
);

  localparam int ID_W     = NODE_ID_BITS;
  localparam int CFG_W    = (NODE_ID_BITS > RAW_W) ? NODE_ID_BITS : RAW_W;
  localparam int G_BITS   = $clog2(MAX_GROUPS + 1);
  localparam int GRP_BITS = $clog2(MAX_GROUPS);
  localparam int LW       = G_BITS + RAW_W;      // leaf switch count
  localparam int PW       = GRP_BITS + 8;        // full global port number
  localparam logic [PORT_W-1:0] PORT_KEEP =
    (PORT_BITS >= PORT_W) ? {PORT_W{1'b1}} : PORT_W'((1 << PORT_BITS) - 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;  // decide whether switch facts need a refresh
  localparam logic [3:0] S_ME1  = 4'd2;  // node id / leaves
  localparam logic [3:0] S_ME2  = 4'd3;  // (node id mod leaves) / a
  localparam logic [3:0] S_DEC  = 4'd4;  // eject and leaf rules
  localparam logic [3:0] S_EJ1  = 4'd5;  // eject_switch / leaves
  localparam logic [3:0] S_EJ2  = 4'd6;  // (eject_switch mod leaves) / a
  localparam logic [3:0] S_RD   = 4'd7;  // group rotor read, offset product
  localparam logic [3:0] S_GL   = 4'd8;  // global port sum
  localparam logic [3:0] S_OUT  = 4'd9;  // hand the result to the output register

  // Configuration.
  logic [ID_W-1:0]   node_id;
  logic [G_BITS-1:0] groups;
  cfg_t              cfg;

  dfpr_cfg #(
    .NODE_ID_BITS (NODE_ID_BITS),
    .MAX_GROUPS   (MAX_GROUPS),
    .CFG_W        (CFG_W),
    .G_BITS       (G_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .node_id_o   (node_id),
    .groups_o    (groups),
    .cfg_o       (cfg)
  );

  // Shared divider.
  logic            div_start;
  logic [ID_W-1:0] div_dividend;
  logic [LW-1:0]   div_divisor;
  logic            div_done;
  logic [ID_W-1:0] div_quot;
  logic [LW-1:0]   div_rem;

  dfpr_div #(
    .ID_W  (ID_W),
    .DIV_W (LW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Control state.
  logic [3:0]          state_q, state_d;
  logic                dirty_q, dirty_d;       // switch facts stale after reset or write
  logic                clr_busy_q, clr_busy_d;
  logic [GRP_BITS-1:0] clr_idx_q, clr_idx_d;
  logic                out_valid_q, out_valid_d;
  logic [ROTOR_W-1:0]  uplink_q, uplink_d;

  // Payload.
  logic [ID_W-1:0]     ej_q, ej_d;
  logic [PORT_W-1:0]   ejp_q, ejp_d;
  logic [LW-1:0]       leaves_q, leaves_d;
  logic                my_leaf_q, my_leaf_d;
  logic [GRP_BITS-1:0] my_g_q, my_g_d;
  logic [GRP_BITS-1:0] dst_g_q, dst_g_d;
  logic [PW-1:0]       prod_q, prod_d;
  logic [ROTOR_W-1:0]  rotor_q, rotor_d;
  logic [PORT_W-1:0]   res_port_q, res_port_d;
  route_kind_e         res_kind_q, res_kind_d;
  logic [PORT_W-1:0]   out_port_q, out_port_d;
  route_kind_e         out_kind_q, out_kind_d;

  // Group rotor memory.
  logic [ROTOR_W-1:0]  rotor_mem [MAX_GROUPS];
  logic [ROTOR_W-1:0]  mem_rd_q;
  logic                mem_we;
  logic [GRP_BITS-1:0] mem_waddr;
  logic [ROTOR_W-1:0]  mem_wdata;
  logic [GRP_BITS-1:0] mem_raddr;

  logic                in_take;
  logic [GRP_BITS-1:0] dst_g;
  logic [GRP_BITS-1:0] off;
  logic [RAW_W-1:0]    rotor_inc;
  logic [RAW_W-1:0]    uplink_inc;
  logic [PW-1:0]       port_full;

  assign in_stall_o = (state_q != S_IDLE) || clr_busy_q;
  assign in_take    = in_valid_i && !in_stall_o;
  assign dst_g      = GRP_BITS'(div_quot);
  assign off        = (my_g_q < dst_g_q) ? dst_g_q - GRP_BITS'(1) : dst_g_q;
  assign rotor_inc  = RAW_W'(mem_rd_q) + RAW_W'(1);
  assign uplink_inc = RAW_W'(uplink_q) + RAW_W'(1);
  assign port_full  = prod_q + PW'(rotor_q) + PW'(cfg.a);
  assign mem_raddr  = dst_g;

  always_comb begin
    state_d     = state_q;
    dirty_d     = dirty_q;
    clr_busy_d  = clr_busy_q;
    clr_idx_d   = clr_idx_q;
    out_valid_d = out_valid_q;
    uplink_d    = uplink_q;
    ej_d        = ej_q;
    ejp_d       = ejp_q;
    leaves_d    = leaves_q;
    my_leaf_d   = my_leaf_q;
    my_g_d      = my_g_q;
    dst_g_d     = dst_g_q;
    prod_d      = prod_q;
    rotor_d     = rotor_q;
    res_port_d  = res_port_q;
    res_kind_d  = res_kind_q;
    out_port_d  = out_port_q;
    out_kind_d  = out_kind_q;
    div_start    = 1'b0;
    div_dividend = ej_q;
    div_divisor  = leaves_q;
    mem_we    = 1'b0;
    mem_waddr = dst_g_q;
    mem_wdata = (rotor_inc == cfg.cov) ? '0 : rotor_inc[ROTOR_W-1:0];

    // Drop the result once the far side takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // Clear the group rotors after reset and after every register write.
    if (cfg.wr) begin
      clr_busy_d = 1'b1;
      clr_idx_d  = '0;
      dirty_d    = 1'b1;
    end else if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + GRP_BITS'(1);
      if (clr_idx_q == GRP_BITS'(MAX_GROUPS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = '0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          ej_d     = eject_switch_i;
          ejp_d    = eject_port_i;
          leaves_d = LW'(groups) * LW'(cfg.a);
          state_d  = S_PREP;
        end
      end
      S_PREP: begin
        if (dirty_q) begin
          div_start    = 1'b1;
          div_dividend = node_id;
          state_d      = S_ME1;
        end else begin
          state_d = S_DEC;
        end
      end
      S_ME1: begin
        if (div_done) begin
          my_leaf_d    = div_quot == '0;
          div_start    = 1'b1;
          div_dividend = ID_W'(div_rem);
          div_divisor  = LW'(cfg.a);
          state_d      = S_ME2;
        end
      end
      S_ME2: begin
        if (div_done) begin
          my_g_d   = dst_g;
          uplink_d = ROTOR_W'(div_rem);
          dirty_d  = 1'b0;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        if (ej_q == node_id) begin
          res_port_d = ejp_q & PORT_KEEP;
          res_kind_d = KIND_EJECT;
          state_d    = S_OUT;
        end else if (my_leaf_q) begin
          // Leaf row: send up, advance the uplink rotor modulo a.
          res_port_d = PORT_W'(uplink_q) & PORT_KEEP;
          res_kind_d = KIND_UPLINK;
          uplink_d   = (uplink_inc == cfg.a) ? '0 : uplink_inc[ROTOR_W-1:0];
          state_d    = S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_EJ1;
        end
      end
      S_EJ1: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = ID_W'(div_rem);
          div_divisor  = LW'(cfg.a);
          state_d      = S_EJ2;
        end
      end
      S_EJ2: begin
        if (div_done) begin
          dst_g_d = dst_g;
          if (dst_g == my_g_q) begin
            res_port_d = PORT_W'(ROTOR_W'(div_rem)) & PORT_KEEP;
            res_kind_d = KIND_LOCAL;
            state_d    = S_OUT;
          end else begin
            // Rotor read address is the quotient this cycle.
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        prod_d  = PW'(off) * PW'(cfg.cov);
        rotor_d = mem_rd_q;
        mem_we  = 1'b1;
        state_d = S_GL;
      end
      S_GL: begin
        res_port_d = port_full[PORT_W-1:0] & PORT_KEEP;
        res_kind_d = KIND_GLOBAL;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_port_d  = res_port_q;
          out_kind_d  = res_kind_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dirty_q     <= 1'b1;
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
      uplink_q    <= '0;
    end else begin
      state_q     <= state_d;
      dirty_q     <= dirty_d;
      clr_busy_q  <= clr_busy_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
      uplink_q    <= uplink_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ej_q       <= ej_d;
    ejp_q      <= ejp_d;
    leaves_q   <= leaves_d;
    my_leaf_q  <= my_leaf_d;
    my_g_q     <= my_g_d;
    dst_g_q    <= dst_g_d;
    prod_q     <= prod_d;
    rotor_q    <= rotor_d;
    res_port_q <= res_port_d;
    res_kind_q <= res_kind_d;
    out_port_q <= out_port_d;
    out_kind_q <= out_kind_d;
  end

  // Group rotors: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rotor_mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= rotor_mem[mem_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign out_port_o   = out_port_q;
  assign route_kind_o = out_kind_q;

  `DFPR_ASSERT_NXT(a_one_packet, in_take, in_stall_o, "second packet taken while busy")
  `DFPR_ASSERT_IMP(a_uplink_range, !dirty_q, RAW_W'(uplink_q) < cfg.a,
                   "uplink rotor out of range")
  `DFPR_ASSERT_IMP(a_clear_blocks, clr_busy_q, in_stall_o, "packet taken during clear")

endmodule

// ===== hw/rtl/dfpr_cfg.sv =====
`timescale 1ns / 1ps

module dfpr_cfg import dfpr_pkg::*; #(
  parameter int NODE_ID_BITS = DFPR_NODE_ID_BITS,
  parameter int MAX_GROUPS   = DFPR_MAX_GROUPS,
  parameter int CFG_W        = (NODE_ID_BITS > RAW_W) ? NODE_ID_BITS : RAW_W,
  parameter int G_BITS       = $clog2(MAX_GROUPS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  output logic [NODE_ID_BITS-1:0] node_id_o,
  output logic [G_BITS-1:0]       groups_o,
  output cfg_t                    cfg_o
);

  localparam int CW = (G_BITS > RAW_W) ? G_BITS : RAW_W;

  logic [NODE_ID_BITS-1:0] node_id_q;
  logic [RAW_W-1:0]        routers_q;
  logic [RAW_W-1:0]        groups_q;
  logic [RAW_W-1:0]        covering_q;
  logic [CW-1:0]           groups_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q  <= '0;
      routers_q  <= ROUTERS_RESET;
      groups_q   <= GROUPS_RESET;
      covering_q <= COVERING_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_NODE_ID:  node_id_q  <= NODE_ID_BITS'(cfg_data_i);
        REG_ROUTERS:  routers_q  <= cfg_data_i[RAW_W-1:0];
        REG_GROUPS:   groups_q   <= cfg_data_i[RAW_W-1:0];
        REG_COVERING: covering_q <= cfg_data_i[RAW_W-1:0];
        default:      node_id_q  <= node_id_q;
      endcase
    end
  end

  // Saturate the sizes into their legal ranges.
  always_comb begin
    groups_ext = CW'(groups_q);
    if (groups_ext < CW'(2)) begin
      groups_o = G_BITS'(2);
    end else if (groups_ext > CW'(MAX_GROUPS)) begin
      groups_o = G_BITS'(MAX_GROUPS);
    end else begin
      groups_o = G_BITS'(groups_ext);
    end
    cfg_o.wr  = cfg_we_i;
    cfg_o.a   = (routers_q == '0) ? RAW_W'(1) :
                (routers_q > ROTOR_LIMIT) ? ROTOR_LIMIT : routers_q;
    cfg_o.cov = (covering_q == '0) ? RAW_W'(1) :
                (covering_q > ROTOR_LIMIT) ? ROTOR_LIMIT : covering_q;
  end

  assign node_id_o = node_id_q;

endmodule

// ===== hw/rtl/dfpr_div.sv =====
`timescale 1ns / 1ps
`include "dragonfly_plus_minimal_route_macros.svh"

module dfpr_div import dfpr_pkg::*; #(
  parameter int ID_W  = DFPR_NODE_ID_BITS,
  parameter int DIV_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ID_W-1:0]  dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [ID_W-1:0]  quot_o,
  output logic [DIV_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(ID_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ID_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             fits;
  logic             last;

  // One restoring step per cycle, quotient bits shift in from the bottom.
  always_comb begin
    shifted = {rem_q, quo_q[ID_W-1]};
    diff    = shifted - {1'b0, div_q};
    fits    = shifted >= {1'b0, div_q};
    last    = cnt_q == CNT_W'(ID_W - 1);
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[ID_W-2:0], fits};
      rem_d = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

  `DFPR_ASSERT_IMP(a_start_when_free, start_i, !busy_q, "divider started while busy")
  `DFPR_ASSERT_NXT(a_start_runs, start_i, busy_q && !done_q, "divider did not start")
  `DFPR_ASSERT_IMP(a_rem_below_div, done_q, rem_q < div_q, "remainder not below divisor")

endmodule
